// ----- rtl/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// sfla_pkg
// Types, constants and codes shared by the free-list allocator modules.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int LIST_COUNT = 32;
    localparam int HEAP_BYTES = 65536;
    localparam int GRANULE    = 16;
    localparam int LINK_DEPTH = HEAP_BYTES / GRANULE;
    localparam int LIST_IDX_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int GRAN_W     = $clog2(LINK_DEPTH);

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 17;
    localparam int ID_W   = 5;
    localparam int SUM_W  = SIZE_W + 2;

    typedef enum logic [1:0] {
        REG_BASE_ADDRESS  = 2'd0,
        REG_HEAP_SIZE     = 2'd1,
        REG_HEADER_ENABLE = 2'd2
    } t_reg_index;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    typedef struct packed {
        logic              command;
        logic [SIZE_W-1:0] request_size;
        logic [ID_W-1:0]   list_id;
        logic [ADDR_W-1:0] block_address;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic              reused;
        logic              overflow;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } t_link;

    typedef struct packed {
        logic capture;
        logic link_rd;
        logic commit_pop;
        logic commit_direct;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_free;
        logic head_valid;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/segregated_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// Per-list LIFO free lists with a bump-pointer fallback.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         i_in_valid / o_in_stall   i_in_data  (t_request)
//   result    out        o_out_valid / i_out_stall o_out_data (t_result)
//   config    in         i_cfg_wr_en               i_cfg_index, i_cfg_wr_data
//
// Free and bump allocate: the request is captured on acceptance, then S_EXEC
// commits the result register. Pop from a list: S_EXEC issues the registered
// read of the link memory, then S_LINK commits the result register.
// Reset: synchronous; every list empty, bump top zero; link memory not cleared.
// A held result stalls only the commit of the next transaction, not its
// acceptance.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [1:0]                   i_cfg_index,
    input  logic [sfla_pkg::ADDR_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  sfla_pkg::t_request           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sfla_pkg::t_result            o_out_data
);
    import sfla_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    sfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sfla_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

// ----- rtl/sfla_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfla_ctrl
// Sequencer: accepts a transaction, then issues either a direct commit or a
// link read followed by a pop commit.
// ----------------------------------------------------------------------------
module sfla_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sfla_pkg::t_dp_status  i_status,
    output sfla_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_in_stall
);
    import sfla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_free || !i_status.head_valid) begin
                    if (i_status.out_free) begin
                        o_cmd.commit_direct = 1'b1;
                        n_state             = S_IDLE;
                    end
                end else begin
                    o_cmd.link_rd = 1'b1;
                    n_state       = S_LINK;
                end
            end
            S_LINK: begin
                if (i_status.out_free) begin
                    o_cmd.commit_pop = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sfla_dp.sv -----
// ----------------------------------------------------------------------------
// sfla_dp
// Datapath: configuration registers, list heads, link memory, bump top and
// the result register.
// ----------------------------------------------------------------------------
module sfla_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [1:0]                   i_cfg_index,
    input  logic [sfla_pkg::ADDR_W-1:0]  i_cfg_wr_data,
    input  sfla_pkg::t_request           i_in_data,
    input  sfla_pkg::t_ctrl_cmd          i_cmd,
    input  logic                         i_out_stall,
    output sfla_pkg::t_dp_status         o_status,
    output logic                         o_out_valid,
    output sfla_pkg::t_result            o_out_data
);
    import sfla_pkg::*;

    logic [ADDR_W-1:0]     r_base;
    logic [SIZE_W-1:0]     r_heap_size;
    logic                  r_hdr_en;

    logic                  r_cmd;
    logic [SIZE_W-1:0]     r_req;
    logic [LIST_IDX_W-1:0] r_id;
    logic [ADDR_W-1:0]     r_block;

    logic [ADDR_W-1:0]     r_heads [LIST_COUNT];
    logic [LIST_COUNT-1:0] r_head_valid;
    logic [SIZE_W-1:0]     r_top;

    t_link                 r_link_mem [LINK_DEPTH];
    t_link                 r_link_rd;

    logic                  r_out_valid;
    t_result               r_out;

    logic [ADDR_W-1:0]     off;
    logic [ADDR_W-1:0]     head;
    logic                  head_valid;
    logic [ADDR_W-1:0]     hdr;
    logic [ADDR_W-1:0]     head_rel;
    logic [ADDR_W-1:0]     hdr_rel;
    logic [GRAN_W-1:0]     pop_gran;
    logic [GRAN_W-1:0]     push_gran;
    logic [SUM_W-1:0]      size;
    logic [SUM_W-1:0]      new_top;
    logic                  bump_over;
    logic                  out_free;

    always_comb begin
        off        = r_hdr_en ? ADDR_W'(GRANULE) : '0;
        head       = r_heads[r_id];
        head_valid = r_head_valid[r_id];
        hdr        = r_block - off;
        head_rel   = head - r_base;
        hdr_rel    = hdr - r_base;
        pop_gran   = head_rel[GRAN_W+3:4];
        push_gran  = hdr_rel[GRAN_W+3:4];
        size       = ((SUM_W'(r_req) + SUM_W'(GRANULE - 1)) & ~SUM_W'(GRANULE - 1))
                     + SUM_W'(off);
        new_top    = SUM_W'(r_top) + size;
        bump_over  = new_top >= SUM_W'(r_heap_size);
        out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_status.is_free    = (r_cmd == CMD_FREE);
    assign o_status.head_valid = head_valid;
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_heap_size <= SIZE_W'(65536);
            r_hdr_en    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BASE_ADDRESS:  r_base      <= i_cfg_wr_data;
                REG_HEAP_SIZE:     r_heap_size <= i_cfg_wr_data[SIZE_W-1:0];
                REG_HEADER_ENABLE: r_hdr_en    <= i_cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_in_data.command;
            r_req   <= i_in_data.request_size;
            r_id    <= LIST_IDX_W'(i_in_data.list_id % LIST_COUNT);
            r_block <= i_in_data.block_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link_rd) begin
            r_link_rd <= r_link_mem[pop_gran];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_direct && r_cmd == CMD_FREE) begin
            r_link_mem[push_gran] <= '{valid: head_valid, addr: head};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_pop) begin
            r_heads[r_id] <= r_link_rd.addr;
        end else if (i_cmd.commit_direct && r_cmd == CMD_FREE) begin
            r_heads[r_id] <= hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_top        <= '0;
        end else if (i_cmd.commit_pop) begin
            r_head_valid[r_id] <= r_link_rd.valid;
        end else if (i_cmd.commit_direct) begin
            if (r_cmd == CMD_FREE) begin
                r_head_valid[r_id] <= 1'b1;
            end else if (!bump_over) begin
                r_top <= new_top[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit_pop || i_cmd.commit_direct) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_pop) begin
            r_out.result_address <= head + off;
            r_out.reused         <= 1'b1;
            r_out.overflow       <= 1'b0;
        end else if (i_cmd.commit_direct) begin
            r_out.reused <= 1'b0;
            if (r_cmd == CMD_FREE) begin
                r_out.result_address <= r_block;
                r_out.overflow       <= 1'b0;
            end else if (bump_over) begin
                r_out.result_address <= '0;
                r_out.overflow       <= 1'b1;
            end else begin
                r_out.result_address <= r_base + ADDR_W'(r_top) + off;
                r_out.overflow       <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/sfla_checker.sv -----
// ----------------------------------------------------------------------------
// sfla_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sfla_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  sfla_pkg::t_request           i_in_data,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  sfla_pkg::t_result            o_out_data
);
    import sfla_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted while busy");

    a_free_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid && i_in_data.command == CMD_FREE
        |-> ##2 (o_out_valid && !o_out_data.reused && !o_out_data.overflow
                 && o_out_data.result_address == $past(i_in_data.block_address, 2)))
        else $error("free did not echo its address");

    a_overflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow
        |-> !o_out_data.reused && o_out_data.result_address == '0)
        else $error("overflow result with address or reuse set");

endmodule

bind segregated_free_list_allocator sfla_checker u_sfla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- verif/sfla_grant_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_grant_checker
// Watches the configuration, request and result channels of the free-list
// allocator. Keeps its own copy of the lists, the link store and the bump
// top, predicts each grant when a request is accepted, and compares every
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sfla_grant_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [1:0]                   i_cfg_index,
    input  logic [sfla_pkg::ADDR_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  sfla_pkg::t_request           i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  sfla_pkg::t_result            i_out_data,
    output int                           o_mismatches,
    output int                           o_pending
);
    import sfla_pkg::*;

    logic [ADDR_W-1:0] cfg_base;
    logic [SIZE_W-1:0] cfg_heap;
    logic              cfg_header;

    logic [ADDR_W-1:0] head_addr [LIST_COUNT];
    logic              head_ok   [LIST_COUNT];
    logic [ADDR_W-1:0] link_addr [LINK_DEPTH];
    logic              link_ok   [LINK_DEPTH];
    logic [ADDR_W-1:0] top_offset;

    t_result expected_grants[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [GRAN_W-1:0] granule(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] rel;
        rel = addr - cfg_base;
        return rel[GRAN_W+3:4];
    endfunction

    task automatic clear_model();
        cfg_base   = '0;
        cfg_heap   = SIZE_W'(HEAP_BYTES);
        cfg_header = 1'b0;
        top_offset = '0;
        for (int i = 0; i < LIST_COUNT; i++) begin
            head_addr[i] = '0;
            head_ok[i]   = 1'b0;
        end
        for (int i = 0; i < LINK_DEPTH; i++) begin
            link_addr[i] = '0;
            link_ok[i]   = 1'b0;
        end
        expected_grants.delete();
        o_pending = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        o_mismatches++;
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic predict_grant(input t_request req);
        t_result               res;
        logic [ADDR_W-1:0]     off;
        logic [ADDR_W-1:0]     hdr;
        logic [ADDR_W-1:0]     size;
        logic [ADDR_W-1:0]     new_top;
        logic [LIST_IDX_W-1:0] id;
        logic [GRAN_W-1:0]     g;
        res = '0;
        off = cfg_header ? ADDR_W'(GRANULE) : '0;
        id  = LIST_IDX_W'(req.list_id % LIST_COUNT);
        if (req.command == CMD_ALLOC) begin
            if (head_ok[id]) begin
                hdr           = head_addr[id];
                g             = granule(hdr);
                head_addr[id] = link_addr[g];
                head_ok[id]   = link_ok[g];
                res.result_address = hdr + off;
                res.reused         = 1'b1;
            end else begin
                size    = ((ADDR_W'(req.request_size) + 32'd15) & ~32'd15) + off;
                new_top = top_offset + size;
                if (new_top >= ADDR_W'(cfg_heap)) begin
                    res.overflow = 1'b1;
                end else begin
                    res.result_address = cfg_base + top_offset + off;
                    top_offset         = new_top;
                end
            end
        end else begin
            hdr           = req.block_address - off;
            g             = granule(hdr);
            link_addr[g]  = head_addr[id];
            link_ok[g]    = head_ok[id];
            head_addr[id] = hdr;
            head_ok[id]   = 1'b1;
            res.result_address = req.block_address;
        end
        expected_grants.push_back(res);
        o_pending = expected_grants.size();
    endtask

    task automatic check_grant(input t_result got);
        t_result want;
        if (expected_grants.size() == 0) begin
            report_mismatch("result with no transaction outstanding", got.result_address, '0);
        end else begin
            want = expected_grants.pop_front();
            o_pending = expected_grants.size();
            if (got.result_address !== want.result_address)
                report_mismatch("result_address", got.result_address, want.result_address);
            if (got.reused !== want.reused)
                report_mismatch("reused", ADDR_W'(got.reused), ADDR_W'(want.reused));
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", ADDR_W'(got.overflow), ADDR_W'(want.overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_BASE_ADDRESS:  cfg_base   = i_cfg_wr_data;
                    REG_HEAP_SIZE:     cfg_heap   = i_cfg_wr_data[SIZE_W-1:0];
                    REG_HEADER_ENABLE: cfg_header = i_cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_grant(i_out_data);
            if (i_in_valid && !i_in_stall) predict_grant(i_in_data);
        end
    end

endmodule

// ----- verif/segregated_free_list_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_tb
// Runs directed allocate and free transactions over the register extremes,
// then random phases mixing allocations, frees of granted blocks and stray
// frees, under varied idling and stalling. A checker beside the block
// predicts every grant; this module drives the block and gives the verdict.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_tb;
    import sfla_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int LIVE_DEPTH  = 64;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] list_id;
    } t_issue;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   list_id;
    } t_live;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [1:0]        cfg_index   = '0;
    logic [ADDR_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    t_request          in_data     = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    t_result           out_data;

    int mismatches;
    int pending;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int sent_count = 0;
    int done_count = 0;
    int hold_left  = 0;
    bit hold_arm   = 1'b0;

    t_issue issued[$];
    t_live  live_blocks[$];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    segregated_free_list_allocator i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data)
    );

    sfla_grant_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always @(posedge clk) begin
        t_issue rec;
        if (out_valid && !out_stall) begin
            done_count++;
            if (issued.size() > 0) begin
                rec = issued.pop_front();
                if (rec.command == CMD_ALLOC && !out_data.overflow) begin
                    live_blocks.push_back('{out_data.result_address, rec.list_id});
                    if (live_blocks.size() > LIVE_DEPTH) void'(live_blocks.pop_front());
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_arm) begin
            hold_arm  = 1'b0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_request make_request(input t_command cmd, input int size,
                                              input int id, input logic [ADDR_W-1:0] addr);
        t_request r;
        r.command       = cmd;
        r.request_size  = SIZE_W'(size);
        r.list_id       = ID_W'(id);
        r.block_address = addr;
        return r;
    endfunction

    function automatic t_request next_request();
        t_request r;
        int       pick;
        int       k;
        r.command       = CMD_ALLOC;
        r.block_address = $urandom();
        r.list_id       = ($urandom_range(99) < 80) ? ID_W'($urandom_range(3))
                                                    : ID_W'($urandom_range(31));
        case ($urandom_range(19))
            0:       r.request_size = SIZE_W'($urandom_range(17'h1FFFF));
            1:       r.request_size = SIZE_W'($urandom_range(1024));
            default: r.request_size = SIZE_W'($urandom_range(128));
        endcase
        pick = $urandom_range(99);
        if (pick >= 45 && pick < 85 && live_blocks.size() > 0) begin
            k = $urandom_range(live_blocks.size() - 1);
            r.command       = CMD_FREE;
            r.block_address = live_blocks[k].addr;
            if ($urandom_range(9) != 0) r.list_id = live_blocks[k].list_id;
            live_blocks.delete(k);
        end else if (pick >= 85) begin
            r.command = CMD_FREE;
        end
        return r;
    endfunction

    task automatic send_request(input t_request req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        issued.push_back('{req.command, req.list_id});
        sent_count++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        wait (done_count == sent_count);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [ADDR_W-1:0] data);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send_request(next_request());
        settle();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, bump only
        send_request(make_request(CMD_ALLOC, 0, 0, '0));
        send_request(make_request(CMD_ALLOC, 1, 31, 32'hFFFF_FFFF));
        send_request(make_request(CMD_ALLOC, 16, 1, '0));
        send_request(make_request(CMD_ALLOC, 17'h1FFFF, 2, '0));
        send_request(make_request(CMD_ALLOC, 65536, 0, '0));
        send_request(make_request(CMD_ALLOC, 65503, 1, '0));
        settle();

        // header on, wrapping base, still no frees
        write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(REG_HEADER_ENABLE, 32'd1);
        send_request(make_request(CMD_ALLOC, 0, 5, '0));
        send_request(make_request(CMD_ALLOC, 33, 6, '0));
        settle();

        // frees from here on: keep the base aligned to the heap span
        write_reg(REG_BASE_ADDRESS, 32'hFFFF_0000);
        send_request(make_request(CMD_FREE, 0, 2, 32'hFFFF_0010));
        send_request(make_request(CMD_ALLOC, 0, 2, '0));
        send_request(make_request(CMD_FREE, 0, 3, 32'h0000_0010));
        send_request(make_request(CMD_ALLOC, 0, 3, '0));
        send_request(make_request(CMD_FREE, 0, 4, 32'h0000_0100));
        send_request(make_request(CMD_FREE, 0, 4, 32'h0000_0100));
        repeat (3) send_request(make_request(CMD_ALLOC, 0, 4, '0));
        send_request(make_request(CMD_FREE, 0, 31, 32'h1234_5677));
        send_request(make_request(CMD_FREE, 0, 7, 32'hFFFF_FFFF));
        send_request(make_request(CMD_ALLOC, 5, 10, '0));
        settle();

        write_reg(REG_BASE_ADDRESS, 32'h0000_0000);
        write_reg(REG_HEADER_ENABLE, 32'd0);
        write_reg(REG_HEAP_SIZE, 32'd16);
        send_request(make_request(CMD_ALLOC, 0, 7, '0));
        send_request(make_request(CMD_ALLOC, 0, 7, '0));
        send_request(make_request(CMD_ALLOC, 0, 31, '0));
        send_request(make_request(CMD_FREE, 17'h1FFFF, 9, '0));
        send_request(make_request(CMD_ALLOC, 0, 9, '0));
        settle();

        write_reg(REG_HEAP_SIZE, 32'd65536);
        hold_arm = 1'b1;
        run_random(PHASE_ITEMS, 0, 0);

        write_reg(REG_BASE_ADDRESS, 32'hFFFF_0000);
        write_reg(REG_HEADER_ENABLE, 32'd1);
        run_random(PHASE_ITEMS, 75, 0);

        write_reg(REG_BASE_ADDRESS, 32'h0012_0000);
        write_reg(REG_HEAP_SIZE, 32'd40000);
        write_reg(REG_HEADER_ENABLE, 32'd0);
        run_random(PHASE_ITEMS, 0, 75);

        write_reg(REG_BASE_ADDRESS, 32'h0000_0000);
        write_reg(REG_HEAP_SIZE, 32'd65536);
        write_reg(REG_HEADER_ENABLE, 32'd1);
        run_random(PHASE_ITEMS, 25, 25);

        write_reg(REG_HEAP_SIZE, 32'd16);
        run_random(PHASE_ITEMS, 0, 0);

        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
